[rtl/core/hrhp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hrhp_pkg: shared types and constants of the HTTP request head parser
// Status codes, phase codes, field widths and the header name tables.
// ----------------------------------------------------------------------------
package hrhp_pkg;

   // fixed field widths
   localparam int BYTE_W       = 8;
   localparam int LIMIT_W      = 6;
   localparam int CLEN_W       = 17;
   localparam int KEY_POS_W    = 5;

   // default buffer size and register reset
   localparam int BUFFER_BYTES_DEFAULT = 128 * 1024;
   localparam logic [LIMIT_W-1:0] HEADER_LIMIT_RESET = LIMIT_W'(32);
   localparam logic [CLEN_W-1:0] CLEN_OUT_MAX = {CLEN_W{1'b1}};

   // header name lengths
   localparam logic [KEY_POS_W-1:0] CL_LEN  = KEY_POS_W'(14);
   localparam logic [KEY_POS_W-1:0] TE_LEN  = KEY_POS_W'(17);
   localparam logic [KEY_POS_W-1:0] KEY_MAX = {KEY_POS_W{1'b1}};

   // special characters
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
   localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
   localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
   localparam logic [BYTE_W-1:0] CH_UZ    = 8'h5A;

   // terminator progress codes
   localparam logic [1:0] TP_NONE    = 2'd0;
   localparam logic [1:0] TP_CR      = 2'd1;
   localparam logic [1:0] TP_CRLF    = 2'd2;
   localparam logic [1:0] TP_CRLFCR  = 2'd3;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD     = 2'd1,
      ST_LEN_REQ = 2'd2,
      ST_DROP    = 2'd3
   } status_type;

   typedef enum logic {
      PH_HEAD = 1'b0,
      PH_BODY = 1'b1
   } phase_type;

   typedef enum logic [1:0] {
      VP_SKIP   = 2'd0,
      VP_DIGITS = 2'd1,
      VP_IGNORE = 2'd2
   } value_phase_type;

   // ascii lower case
   function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
      to_lower = (c >= CH_UA && c <= CH_UZ) ? c + 8'd32 : c;
   endfunction

   // "content-length" by position
   function automatic logic [BYTE_W-1:0] cl_char(input logic [KEY_POS_W-1:0] pos);
      unique case (pos)
         5'd0:  cl_char = "c";
         5'd1:  cl_char = "o";
         5'd2:  cl_char = "n";
         5'd3:  cl_char = "t";
         5'd4:  cl_char = "e";
         5'd5:  cl_char = "n";
         5'd6:  cl_char = "t";
         5'd7:  cl_char = "-";
         5'd8:  cl_char = "l";
         5'd9:  cl_char = "e";
         5'd10: cl_char = "n";
         5'd11: cl_char = "g";
         5'd12: cl_char = "t";
         5'd13: cl_char = "h";
         default: cl_char = 8'h00;
      endcase
   endfunction

   // "transfer-encoding" by position
   function automatic logic [BYTE_W-1:0] te_char(input logic [KEY_POS_W-1:0] pos);
      unique case (pos)
         5'd0:  te_char = "t";
         5'd1:  te_char = "r";
         5'd2:  te_char = "a";
         5'd3:  te_char = "n";
         5'd4:  te_char = "s";
         5'd5:  te_char = "f";
         5'd6:  te_char = "e";
         5'd7:  te_char = "r";
         5'd8:  te_char = "-";
         5'd9:  te_char = "e";
         5'd10: te_char = "n";
         5'd11: te_char = "c";
         5'd12: te_char = "o";
         5'd13: te_char = "d";
         5'd14: te_char = "i";
         5'd15: te_char = "n";
         5'd16: te_char = "g";
         default: te_char = 8'h00;
      endcase
   endfunction

endpackage
`default_nettype wire

[rtl/core/hrhp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hrhp_if: channels of the HTTP request head parser
// Request byte channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface hrhp_req_if
   import hrhp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              peer_closed;

   modport source (output valid, in_byte, peer_closed, input ready);
   modport sink (input valid, in_byte, peer_closed, output ready);
endinterface

interface hrhp_rsp_if
   import hrhp_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic               has_byte;
   logic [BYTE_W-1:0]  body_byte;
   logic [CLEN_W-1:0]  content_length;
   logic [LIMIT_W-1:0] header_count;
   logic               last;

   modport source (output valid, status, has_byte, body_byte, content_length,
                   header_count, last, input ready);
   modport sink (input valid, status, has_byte, body_byte, content_length,
                 header_count, last, output ready);
endinterface

interface hrhp_csr_if
   import hrhp_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [LIMIT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/core/http_request_head_parser_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// http_request_head_parser_top: HTTP/1.1 request head parser
// Checks the request head, extracts Content-Length and passes the body.
// ----------------------------------------------------------------------------
// One request byte (or a peer-closed event) is taken per clock cycle, every
// cycle, as long as the result register is free or being drained. All parsing
// state updates in the cycle the request is accepted; its result, if any,
// appears in the result register on the next cycle. A head byte gives a result
// only at the end of the request (bad request, length required, dropped, or
// ok with no body); each body byte gives one result, the final one marked last.
// The header limit register is written through the csr channel, which is
// always ready, and must only be written while the parser is idle.
module http_request_head_parser_top
   import hrhp_pkg::*;
#(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   hrhp_req_if.sink   req_chan,
   hrhp_rsp_if.source rsp_chan,
   hrhp_csr_if.sink   csr_chan
);

   // accumulator holds up to BUFFER_BYTES, counters stay below it
   localparam int AW = $clog2(BUFFER_BYTES + 1);
   localparam int CW = $clog2(BUFFER_BYTES);
   localparam logic [AW+3:0] ACC_SAT   = (AW+4)'(BUFFER_BYTES);
   localparam logic [AW:0]   BUF_FULL  = (AW+1)'(BUFFER_BYTES);
   localparam logic [CW-1:0] HEAD_MAX  = CW'(BUFFER_BYTES - 1);

   typedef struct packed {
      logic            in_status_line;
      logic [1:0]      token_count;
      logic            in_token;
      logic            colon_seen;
      logic [KEY_POS_W-1:0] key_position;
      logic [1:0]      key_match;
      value_phase_type value_phase;
      logic [AW-1:0]   acc;
      logic            err_bad;
      logic            err_te;
   } line_state_type;

   localparam line_state_type LS_RESET = '{
      in_status_line: 1'b1,
      token_count:    2'd0,
      in_token:       1'b0,
      colon_seen:     1'b0,
      key_position:   '0,
      key_match:      2'b11,
      value_phase:    VP_SKIP,
      acc:            '0,
      err_bad:        1'b0,
      err_te:         1'b0
   };

   // one head byte through the status line / header line scanner
   function automatic line_state_type feed(input line_state_type s,
                                           input logic [BYTE_W-1:0] c);
      line_state_type    r;
      logic              is_digit;
      logic [AW+3:0]     prod;
      logic [BYTE_W-1:0] lc;
      r        = s;
      is_digit = (c >= CH_0) && (c <= CH_9);
      lc       = to_lower(c);
      prod     = ({4'd0, s.acc} << 3) + ({4'd0, s.acc} << 1)
                 + (AW+4)'(c - CH_0);
      if (s.in_status_line) begin
         if (c == CH_SP) begin
            r.in_token = 1'b0;
         end else if (!s.in_token) begin
            r.in_token = 1'b1;
            if (s.token_count != 2'd3) r.token_count = s.token_count + 2'd1;
         end
      end else if (!s.err_bad) begin
         if (!s.colon_seen) begin
            if (c == CH_COLON) begin
               r.colon_seen = 1'b1;
               if (s.key_match[1] && s.key_position == TE_LEN) r.err_te = 1'b1;
               if (s.key_match[0] && s.key_position == CL_LEN) begin
                  r.acc         = '0;
                  r.value_phase = VP_SKIP;
               end else begin
                  r.value_phase = VP_IGNORE;
               end
            end else begin
               if (!(s.key_position < CL_LEN && lc == cl_char(s.key_position)))
                  r.key_match[0] = 1'b0;
               if (!(s.key_position < TE_LEN && lc == te_char(s.key_position)))
                  r.key_match[1] = 1'b0;
               if (s.key_position != KEY_MAX)
                  r.key_position = s.key_position + KEY_POS_W'(1);
            end
         end else begin
            unique case (s.value_phase)
               VP_SKIP: begin
                  if (!(c == CH_SP || c == CH_TAB)) begin
                     if (is_digit) begin
                        r.acc         = AW'(c - CH_0);
                        r.value_phase = VP_DIGITS;
                     end else begin
                        r.value_phase = VP_IGNORE;
                     end
                  end
               end
               VP_DIGITS: begin
                  if (is_digit) begin
                     r.acc = (prod > ACC_SAT) ? AW'(BUFFER_BYTES) : prod[AW-1:0];
                  end else begin
                     r.value_phase = VP_IGNORE;
                  end
               end
               default: begin
               end
            endcase
         end
      end
      feed = r;
   endfunction

   // state registers
   phase_type          phase_ff, phase_in;
   logic [1:0]         tp_ff, tp_in;
   logic [CW-1:0]      byte_count_ff, byte_count_in;
   logic [CW-1:0]      body_rem_ff, body_rem_in;
   line_state_type     ls_ff, ls_in;
   logic [LIMIT_W-1:0] lines_seen_ff, lines_seen_in;
   logic [LIMIT_W-1:0] header_limit_ff, header_limit_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   logic               has_byte_ff, has_byte_in;
   logic [BYTE_W-1:0]  body_byte_ff, body_byte_in;
   logic [CLEN_W-1:0]  clen_ff, clen_in;
   logic [LIMIT_W-1:0] hcount_ff, hcount_in;
   logic               last_ff, last_in;

   logic               req_fire;
   logic               emit;
   logic [BYTE_W-1:0]  c;
   logic [CW-1:0]      bc;
   logic [CW-1:0]      rem_dec;
   logic [AW:0]        head_total;
   logic               prev_cr;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign c              = req_chan.in_byte;
   assign bc             = byte_count_ff + CW'(1);
   assign rem_dec        = body_rem_ff - CW'(body_rem_ff != '0);
   assign head_total     = (AW+1)'(bc) + (AW+1)'(ls_ff.acc);
   assign prev_cr        = (tp_ff == TP_CR) || (tp_ff == TP_CRLFCR);

   // register write
   always_comb begin
      header_limit_in = header_limit_ff;
      if (csr_chan.valid) header_limit_in = csr_chan.data;
   end

   // per-request parse step
   always_comb begin
      phase_in      = phase_ff;
      tp_in         = tp_ff;
      byte_count_in = byte_count_ff;
      body_rem_in   = body_rem_ff;
      ls_in         = ls_ff;
      lines_seen_in = lines_seen_ff;
      emit          = 1'b0;
      status_in     = ST_OK;
      has_byte_in   = 1'b0;
      body_byte_in  = '0;
      last_in       = 1'b0;
      if (req_fire) begin
         if (req_chan.peer_closed) begin
            emit      = 1'b1;
            status_in = ST_DROP;
            last_in   = 1'b1;
         end else if (phase_ff == PH_BODY) begin
            body_rem_in  = rem_dec;
            emit         = 1'b1;
            has_byte_in  = 1'b1;
            body_byte_in = c;
            last_in      = (rem_dec == '0);
         end else begin
            byte_count_in = bc;
            if (c == CH_LF && tp_ff == TP_CRLFCR) begin
               // head complete: decide the outcome
               tp_in = TP_NONE;
               priority if (ls_ff.err_bad) begin
                  emit = 1'b1; status_in = ST_BAD; last_in = 1'b1;
               end else if (ls_ff.err_te) begin
                  emit = 1'b1; status_in = ST_LEN_REQ; last_in = 1'b1;
               end else if (head_total >= BUF_FULL) begin
                  emit = 1'b1; status_in = ST_DROP; last_in = 1'b1;
               end else if (ls_ff.acc == '0) begin
                  emit = 1'b1; status_in = ST_OK; last_in = 1'b1;
               end else begin
                  phase_in    = PH_BODY;
                  body_rem_in = ls_ff.acc[CW-1:0];
               end
            end else begin
               if (c == CH_LF && tp_ff == TP_CR) begin
                  // line end
                  if (ls_ff.in_status_line) begin
                     if (ls_ff.token_count != 2'd3) ls_in.err_bad = 1'b1;
                     ls_in.in_status_line = 1'b0;
                  end else if (!ls_ff.err_bad) begin
                     if (!ls_ff.colon_seen || lines_seen_ff >= header_limit_ff)
                        ls_in.err_bad = 1'b1;
                     else
                        lines_seen_in = lines_seen_ff + LIMIT_W'(1);
                  end
                  ls_in.colon_seen   = 1'b0;
                  ls_in.key_position = '0;
                  ls_in.key_match    = 2'b11;
                  ls_in.value_phase  = VP_SKIP;
                  tp_in              = TP_CRLF;
               end else begin
                  // a held CR that did not start a line end is an ordinary byte
                  if (prev_cr) ls_in = feed(ls_in, CH_CR);
                  if (c == CH_CR) begin
                     tp_in = (tp_ff == TP_CRLF) ? TP_CRLFCR : TP_CR;
                  end else begin
                     ls_in = feed(ls_in, c);
                     tp_in = TP_NONE;
                  end
               end
               if (bc >= HEAD_MAX) begin
                  emit = 1'b1; status_in = ST_DROP; last_in = 1'b1;
               end
            end
         end
      end
      // result snapshot of the updated state
      clen_in   = (ls_in.acc > AW'(CLEN_OUT_MAX)) ? CLEN_OUT_MAX : CLEN_W'(ls_in.acc);
      hcount_in = lines_seen_in;
      // restart after the final result
      if (emit && last_in) begin
         phase_in      = PH_HEAD;
         tp_in         = TP_NONE;
         byte_count_in = '0;
         body_rem_in   = '0;
         ls_in         = LS_RESET;
         lines_seen_in = '0;
      end
      // result register occupancy
      rsp_valid_in = rsp_valid_ff;
      if (emit)                rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEAD;
         tp_ff           <= TP_NONE;
         byte_count_ff   <= '0;
         body_rem_ff     <= '0;
         ls_ff           <= LS_RESET;
         lines_seen_ff   <= '0;
         header_limit_ff <= HEADER_LIMIT_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         tp_ff           <= tp_in;
         byte_count_ff   <= byte_count_in;
         body_rem_ff     <= body_rem_in;
         ls_ff           <= ls_in;
         lines_seen_ff   <= lines_seen_in;
         header_limit_ff <= header_limit_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (emit) begin
         status_ff    <= status_in;
         has_byte_ff  <= has_byte_in;
         body_byte_ff <= body_byte_in;
         clen_ff      <= clen_in;
         hcount_ff    <= hcount_in;
         last_ff      <= last_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.has_byte       = has_byte_ff;
   assign rsp_chan.body_byte      = body_byte_ff;
   assign rsp_chan.content_length = clen_ff;
   assign rsp_chan.header_count   = hcount_ff;
   assign rsp_chan.last           = last_ff;

endmodule
`default_nettype wire

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: regression bench for the HTTP request head parser
// Request bytes go in through the request channel with random gaps. A parser
// model kept in this bench predicts each reply, and every reply is checked
// field by field in arrival order. Directed heads come first, then random
// traffic under several header limits.
// ----------------------------------------------------------------------------
module tb;
   import hrhp_pkg::*;

   localparam int          BUF_BYTES    = 128 * 1024;
   localparam int          RANDOM_ITEMS = 550;
   localparam int          CYCLE_LIMIT  = 2_000_000;
   localparam int          SETTLE_WAIT  = 4;
   localparam logic [16:0] CLEN_SAT     = 17'h1FFFF;

   // characters the parser reacts to
   localparam logic [7:0] ASC_CR    = 8'h0D;
   localparam logic [7:0] ASC_LF    = 8'h0A;
   localparam logic [7:0] ASC_SP    = 8'h20;
   localparam logic [7:0] ASC_TAB   = 8'h09;
   localparam logic [7:0] ASC_COLON = 8'h3A;
   localparam logic [7:0] ASC_0     = 8'h30;
   localparam logic [7:0] ASC_9     = 8'h39;

   // header names the parser looks for, lower case
   localparam int                CL_KEY_LEN = 14;
   localparam int                TE_KEY_LEN = 17;
   localparam logic [8*14-1:0]   CL_KEY     = "content-length";
   localparam logic [8*17-1:0]   TE_KEY     = "transfer-encoding";

   typedef enum logic [1:0] {
      EOL_NONE    = 2'd0,
      EOL_CR      = 2'd1,
      EOL_CRLF    = 2'd2,
      EOL_CRLFCR  = 2'd3
   } eol_state_type;

   typedef struct packed {
      status_type  status;
      logic        has_byte;
      logic [7:0]  body_byte;
      logic [16:0] content_length;
      logic [5:0]  header_count;
      logic        last;
   } parse_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hrhp_req_if req_chan ();
   hrhp_rsp_if rsp_chan ();
   hrhp_csr_if csr_chan ();

   http_request_head_parser_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #6 clock = ~clock;

   // parser state as predicted
   phase_type       prs_phase;
   eol_state_type   eol;
   logic [16:0]     head_bytes;
   logic            on_start_line;
   logic [1:0]      word_count;
   logic            in_word;
   logic [5:0]      hdr_lines;
   logic            colon_found;
   logic [4:0]      name_pos;
   logic [1:0]      name_hits;
   value_phase_type val_state;
   logic [17:0]     len_acc;
   logic            bad_req;
   logic            te_seen;
   logic [16:0]     body_left;
   logic [5:0]      hdr_limit;

   parse_reply_type parser_replies_due [$];

   logic calm = 1'b0;
   int   req_accepted = 0;
   int   limit_writes = 0;
   int   mismatches = 0;
   int   messages_closed = 0;
   int   body_bytes_seen = 0;
   int   cycle_count = 0;
   int   status_seen [4] = '{0, 0, 0, 0};

   // ------------------------------------------------------------------
   // parser prediction
   // ------------------------------------------------------------------

   function automatic void restart_parser();
      prs_phase     = PH_HEAD;
      eol           = EOL_NONE;
      head_bytes    = '0;
      on_start_line = 1'b1;
      word_count    = '0;
      in_word       = 1'b0;
      hdr_lines     = '0;
      colon_found   = 1'b0;
      name_pos      = '0;
      name_hits     = 2'b11;
      val_state     = VP_SKIP;
      len_acc       = '0;
      bad_req       = 1'b0;
      te_seen       = 1'b0;
      body_left     = '0;
   endfunction

   function automatic logic [7:0] fold_case(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   // queue one reply; a final reply starts a fresh message
   function automatic void post_reply(status_type st, logic has, logic [7:0] b, logic fin);
      parse_reply_type r;
      r.status         = st;
      r.has_byte       = has;
      r.body_byte      = has ? b : 8'h00;
      r.content_length = (len_acc > 18'(CLEN_SAT)) ? CLEN_SAT : len_acc[16:0];
      r.header_count   = hdr_lines;
      r.last           = fin;
      parser_replies_due.push_back(r);
      if (fin)
         restart_parser();
   endfunction

   // one head character that is not part of a line end
   function automatic void absorb_char(logic [7:0] c);
      int unsigned nxt;
      // status line: count space separated words
      if (on_start_line) begin
         if (c == ASC_SP) begin
            in_word = 1'b0;
         end else if (!in_word) begin
            in_word = 1'b1;
            if (word_count < 2'd3)
               word_count = word_count + 2'd1;
         end
         return;
      end
      if (bad_req)
         return;
      // header name: match both names until the colon
      if (!colon_found) begin
         if (c == ASC_COLON) begin
            colon_found = 1'b1;
            if (name_hits[1] && name_pos == TE_KEY_LEN)
               te_seen = 1'b1;
            if (name_hits[0] && name_pos == CL_KEY_LEN) begin
               len_acc   = '0;
               val_state = VP_SKIP;
            end else begin
               val_state = VP_IGNORE;
            end
            return;
         end
         if (!(name_pos < CL_KEY_LEN &&
               fold_case(c) == CL_KEY[8*(CL_KEY_LEN-1-int'(name_pos)) +: 8]))
            name_hits[0] = 1'b0;
         if (!(name_pos < TE_KEY_LEN &&
               fold_case(c) == TE_KEY[8*(TE_KEY_LEN-1-int'(name_pos)) +: 8]))
            name_hits[1] = 1'b0;
         if (name_pos < 5'd31)
            name_pos = name_pos + 5'd1;
         return;
      end
      // header value: blanks, then decimal digits
      case (val_state)
         VP_SKIP: begin
            if (c == ASC_SP || c == ASC_TAB)
               return;
            if (c >= ASC_0 && c <= ASC_9) begin
               len_acc   = 18'(c - ASC_0);
               val_state = VP_DIGITS;
            end else begin
               val_state = VP_IGNORE;
            end
         end
         VP_DIGITS: begin
            if (c >= ASC_0 && c <= ASC_9) begin
               nxt = len_acc * 10 + (c - ASC_0);
               if (nxt > BUF_BYTES)
                  nxt = BUF_BYTES;
               len_acc = 18'(nxt);
            end else begin
               val_state = VP_IGNORE;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void close_line();
      if (on_start_line) begin
         if (word_count < 2'd3)
            bad_req = 1'b1;
         on_start_line = 1'b0;
      end else if (!bad_req) begin
         if (!colon_found || hdr_lines >= hdr_limit)
            bad_req = 1'b1;
         else
            hdr_lines = hdr_lines + 6'd1;
      end
      colon_found = 1'b0;
      name_pos    = '0;
      name_hits   = 2'b11;
      val_state   = VP_SKIP;
   endfunction

   // advance the parser by one accepted request
   function automatic void parse_byte(logic [7:0] c, logic closed);
      logic        saw_cr;
      int unsigned len;
      if (closed) begin
         post_reply(ST_DROP, 1'b0, 8'h00, 1'b1);
         return;
      end
      // body pass-through
      if (prs_phase == PH_BODY) begin
         if (body_left != 0)
            body_left = body_left - 17'd1;
         post_reply(ST_OK, 1'b1, c, body_left == 0);
         return;
      end
      head_bytes = head_bytes + 17'd1;
      saw_cr = (eol == EOL_CR || eol == EOL_CRLFCR);
      // blank line closes the head
      if (c == ASC_LF && eol == EOL_CRLFCR) begin
         len = len_acc;
         eol = EOL_NONE;
         if (bad_req)
            post_reply(ST_BAD, 1'b0, 8'h00, 1'b1);
         else if (te_seen)
            post_reply(ST_LEN_REQ, 1'b0, 8'h00, 1'b1);
         else if (head_bytes + len >= BUF_BYTES)
            post_reply(ST_DROP, 1'b0, 8'h00, 1'b1);
         else if (len == 0)
            post_reply(ST_OK, 1'b0, 8'h00, 1'b1);
         else begin
            prs_phase = PH_BODY;
            body_left = 17'(len);
         end
         return;
      end
      if (c == ASC_LF && eol == EOL_CR) begin
         close_line();
         eol = EOL_CRLF;
      end else begin
         // a held CR not followed by LF is an ordinary byte
         if (saw_cr)
            absorb_char(ASC_CR);
         if (c == ASC_CR) begin
            if (eol == EOL_CRLF)
               eol = EOL_CRLFCR;
            else
               eol = EOL_CR;
         end else begin
            absorb_char(c);
            eol = EOL_NONE;
         end
      end
      // head that never ends
      if (head_bytes >= BUF_BYTES - 1)
         post_reply(ST_DROP, 1'b0, 8'h00, 1'b1);
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   // one request, with random gaps in front of it
   task automatic send_byte(logic [7:0] b, logic closed);
      while (!calm && $urandom_range(99) < 19) begin
         req_chan.valid   <= 1'b0;
         req_chan.in_byte <= 8'($urandom);
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.in_byte     <= b;
      req_chan.peer_closed <= closed;
      do @(posedge clock); while (!req_chan.ready);
      req_accepted++;
      parse_byte(b, closed);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], 1'b0);
   endtask

   task automatic send_crlf();
      send_byte(ASC_CR, 1'b0);
      send_byte(ASC_LF, 1'b0);
   endtask

   task automatic send_line(string s);
      send_text(s);
      send_crlf();
   endtask

   task automatic send_decimal(int unsigned v);
      string t;
      t = $sformatf("%0d", v);
      send_text(t);
   endtask

   // letters of a name in random case
   task automatic send_mixed(string s);
      logic [7:0] c;
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (c >= "a" && c <= "z" && $urandom_range(1) == 1)
            c = c - 8'd32;
         send_byte(c, 1'b0);
      end
   endtask

   // printable word without colon, now and then a NUL
   task automatic send_word(int n);
      logic [7:0] b;
      repeat (n) begin
         b = 8'($urandom_range(33, 126));
         if (b == ASC_COLON)
            b = "_";
         if ($urandom_range(29) == 0)
            b = 8'h00;
         send_byte(b, 1'b0);
      end
   endtask

   task automatic send_body(int n);
      repeat (n) send_byte(8'($urandom), 1'b0);
   endtask

   // status line, n plain header lines and the blank line
   task automatic send_headed_message(int n);
      send_line("GET /idx HTTP/1.1");
      for (int i = 0; i < n; i++)
         send_line("H: v");
      send_crlf();
   endtask

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(4))
         0: return ASC_CR;
         1: return ASC_LF;
         2: return ASC_SP;
         3: return ASC_COLON;
         default: return 8'($urandom);
      endcase
   endfunction

   // stop sending and wait until every reply is in
   task automatic settle_parser();
      req_chan.valid <= 1'b0;
      while (parser_replies_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // header limit write; a message in progress is closed first
   task automatic write_limit(logic [5:0] v);
      if (prs_phase == PH_BODY || head_bytes != 0)
         send_byte(8'($urandom), 1'b1);
      settle_parser();
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= v;
      do @(posedge clock); while (!csr_chan.ready);
      hdr_limit = v;
      csr_chan.valid <= 1'b0;
      limit_writes++;
   endtask

   task automatic send_random_header();
      int kind;
      kind = $urandom_range(99);
      if (kind < 40) begin
         send_mixed("content-length");
         send_byte(ASC_COLON, 1'b0);
         repeat ($urandom_range(2))
            send_byte(($urandom_range(1) == 1) ? ASC_SP : ASC_TAB, 1'b0);
         case ($urandom_range(9))
            0: send_word(2);
            1: send_decimal($urandom_range(200000));
            2: ;
            default: send_decimal($urandom_range(12));
         endcase
      end else if (kind < 46) begin
         send_mixed("transfer-encoding");
         send_text(": chunked");
      end else if (kind < 51) begin
         send_word($urandom_range(1, 6));
      end else if (kind < 53) begin
         send_mixed("content-lengt");
         send_text(": 7");
      end else if (kind < 56) begin
         send_mixed("content-length-x");
         send_text(": 7");
      end else begin
         send_word($urandom_range(1, 5));
         send_text(": ");
         send_word($urandom_range(0, 4));
         if ($urandom_range(14) == 0) begin
            send_byte(ASC_CR, 1'b0);
            send_word(1);
         end
      end
      send_crlf();
   endtask

   // mostly well formed messages with random content, some noise
   task automatic send_random_message();
      int kind;
      int words;
      kind = $urandom_range(99);
      if (kind < 6) begin
         repeat ($urandom_range(1, 12)) send_byte(noise_byte(), 1'b0);
         return;
      end
      if (kind < 9) begin
         send_byte(8'($urandom), 1'b1);
         return;
      end
      words = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 4);
      if ($urandom_range(4) == 0)
         send_byte(ASC_SP, 1'b0);
      for (int i = 0; i < words; i++) begin
         if (i != 0)
            repeat ($urandom_range(1, 2)) send_byte(ASC_SP, 1'b0);
         send_word($urandom_range(1, 4));
      end
      send_crlf();
      repeat ($urandom_range(3)) send_random_header();
      if ($urandom_range(19) == 0) begin
         send_byte(8'($urandom), 1'b1);
         return;
      end
      send_crlf();
      while (prs_phase == PH_BODY)
         send_byte(8'($urandom), $urandom_range(49) == 0);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   task automatic test_plain_heads();
      send_line("GET / HTTP/1.1");
      send_line("Host: example");
      send_crlf();
      // extra words and spaces on the status line
      send_line("  HEAD   /a  HTTP/1.0  extra");
      send_crlf();
      // NUL and lone CR are plain value bytes
      send_line("PUT /b HTTP/1.1");
      send_text("X-Raw: a");
      send_byte(8'h00, 1'b0);
      send_byte(ASC_CR, 1'b0);
      send_text("b");
      send_crlf();
      send_text("X-Two: v");
      send_byte(ASC_CR, 1'b0);
      send_crlf();
      send_crlf();
   endtask

   task automatic test_body_bytes();
      send_line("POST /u HTTP/1.1");
      send_line("Content-Length: \t 3");
      send_crlf();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b0);
      // the last length header wins
      send_line("POST /v HTTP/1.1");
      send_line("Content-Length: 9");
      send_line("cONTENT-lENGTH:2");
      send_crlf();
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b0);
      // no digits gives zero
      send_line("POST /w HTTP/1.1");
      send_line("Content-Length: abc");
      send_crlf();
      // digits stop at the first other byte
      send_line("POST /x HTTP/1.1");
      send_line("Content-Length: 4;x");
      send_crlf();
      send_body(4);
      // names that only come close
      send_line("POST /y HTTP/1.1");
      send_line("Content-Lengthy: 5");
      send_line("Content-Lengt: 5");
      send_crlf();
   endtask

   task automatic test_bad_requests();
      send_line("GET /");
      send_crlf();
      // empty status line
      send_crlf();
      send_crlf();
      // later headers are not looked at once the head is bad
      send_line("GET / HTTP/1.1");
      send_line("NoColonHere");
      send_line("Content-Length: 5");
      send_crlf();
      send_line("GET / HTTP/1.1");
      send_line("A: 1");
      send_line(" broken");
      send_crlf();
   endtask

   task automatic test_length_required();
      send_line("POST / HTTP/1.1");
      send_line("Transfer-Encoding: chunked");
      send_crlf();
      send_line("POST / HTTP/1.1");
      send_line("content-length: 4");
      send_line("TRANSFER-encoding: gzip");
      send_crlf();
      // bad request outranks length required
      send_line("POST /");
      send_line("Transfer-Encoding: chunked");
      send_crlf();
   endtask

   task automatic test_drops();
      send_byte(8'hC3, 1'b1);
      send_text("GET / HT");
      send_byte(8'h00, 1'b1);
      // close in the middle of the body
      send_line("POST / HTTP/1.1");
      send_line("Content-Length: 6");
      send_crlf();
      send_body(2);
      send_byte(8'h7E, 1'b1);
      // head plus body that still fits within the buffer
      send_line("POST / HTTP/1.1");
      send_line("Content-Length: 131000");
      send_crlf();
      // a head with a saturated length, taken as body bytes of the message above
      send_line("POST / HTTP/1.1");
      send_line("Content-Length: 0000099999999");
      send_crlf();
   endtask

   task automatic test_header_limit();
      write_limit(6'd0);
      send_headed_message(1);
      send_headed_message(0);
      write_limit(6'd1);
      send_headed_message(1);
      send_headed_message(2);
      // above the usual range the value is taken as is
      write_limit(6'd63);
      send_headed_message(40);
      write_limit(6'd32);
      send_headed_message(33);
      send_headed_message(32);
   endtask

   // a head without any line feed runs into the buffer end
   task automatic test_endless_head();
      logic [7:0] b;
      repeat (BUF_BYTES - 1) begin
         b = 8'($urandom);
         if (b == ASC_LF)
            b = "x";
         send_byte(b, 1'b0);
      end
   endtask

   task automatic test_random_traffic();
      int first;
      int n;
      first = req_accepted;
      n = 0;
      while (req_accepted - first < RANDOM_ITEMS) begin
         calm = (n >= 6 && n < 12);
         if (n % 5 == 4 && $urandom_range(2) == 0)
            write_limit(($urandom_range(9) == 0) ? 6'd63 : 6'($urandom_range(5)));
         // hold off until the parser has answered everything
         if (n == 8)
            settle_parser();
         send_random_message();
         n++;
      end
      calm = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // reply checking and receiver stalls
   // ------------------------------------------------------------------

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : reply_check
      parse_reply_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (parser_replies_due.size() == 0) begin
               $error("reply with none expected: status %0d", rsp_chan.status);
               mismatches++;
            end else begin
               want = parser_replies_due.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_chan.status));
               compare_field("has_byte", 32'(want.has_byte), 32'(rsp_chan.has_byte));
               compare_field("body_byte", 32'(want.body_byte), 32'(rsp_chan.body_byte));
               compare_field("content_length", 32'(want.content_length),
                             32'(rsp_chan.content_length));
               compare_field("header_count", 32'(want.header_count),
                             32'(rsp_chan.header_count));
               compare_field("last", 32'(want.last), 32'(rsp_chan.last));
               if (want.has_byte)
                  body_bytes_seen++;
               if (want.last) begin
                  messages_closed++;
                  status_seen[want.status]++;
               end
            end
         end
         rsp_chan.ready <= calm || ($urandom_range(99) >= 19);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------

   initial begin
      req_chan.valid       <= 1'b0;
      req_chan.in_byte     <= 8'h00;
      req_chan.peer_closed <= 1'b0;
      csr_chan.valid       <= 1'b0;
      csr_chan.data        <= '0;
      hdr_limit = HEADER_LIMIT_RESET;
      restart_parser();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_plain_heads();
      test_body_bytes();
      test_bad_requests();
      test_length_required();
      test_drops();
      test_header_limit();
      test_endless_head();
      test_random_traffic();
      settle_parser();

      $display("%0d requests accepted, %0d limit writes, %0d messages closed, %0d body bytes",
               req_accepted, limit_writes, messages_closed, body_bytes_seen);
      $display("outcomes: ok %0d, bad %0d, length required %0d, dropped %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
